// ===== src/two_level_page_map_top_macros.svh =====
// assertion macros for the two-level page map
`ifndef TWO_LEVEL_PAGE_MAP_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_MAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TLPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlpm: same-cycle check failed");
`define TLPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlpm: next-cycle check failed");
`else
`define TLPM_ASSERT_IMP(lbl, ante, cons)
`define TLPM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/tlpm_pkg.sv =====
// shared types and constants of the two-level page map
`default_nettype none

package tlpm_pkg;

  localparam int TABLE_SLOTS  = 64;
  localparam int DIR_ENTRIES  = 1024;
  localparam int TBL_ENTRIES  = 1024;
  localparam int PAGE_SHIFT   = 12;
  localparam int ADDR_W       = 32;
  localparam int FRAME_W      = 20;
  localparam int DIR_AW       = $clog2(DIR_ENTRIES);
  localparam int TBL_AW       = $clog2(TBL_ENTRIES);
  localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SLOT_CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int PG_AW        = SLOT_W + TBL_AW;
  localparam int PAGE_DEPTH   = TABLE_SLOTS * TBL_ENTRIES;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_W        = 32;
  localparam int ST_W         = 3;
  localparam int TDATA_IN_W   = 56;
  localparam int TDATA_OUT_W  = 56;

  localparam int IN_VA_LSB    = 0;
  localparam int IN_FR_LSB    = IN_VA_LSB + ADDR_W;
  localparam int IN_REL_BIT   = IN_FR_LSB + FRAME_W;
  localparam int OUT_PA_LSB   = 0;
  localparam int OUT_ST_LSB   = OUT_PA_LSB + ADDR_W;
  localparam int OUT_FF_LSB   = OUT_ST_LSB + ST_W;
  localparam int OUT_FV_BIT   = OUT_FF_LSB + FRAME_W;

  localparam logic [ADDR_W-1:0] RESET_LOAD_OFFSET = 32'hC000_0000;

  localparam logic [1:0] REQ_XLATE = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_UNMAP = 2'd2;

  localparam logic CFG_PAGING_ON   = 1'b0;
  localparam logic CFG_LOAD_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    OP_NULL   = 3'd0,
    OP_DIRECT = 3'd1,
    OP_XLATE  = 3'd2,
    OP_MAP    = 3'd3,
    OP_UNMAP  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NO_TABLE    = 3'd1,
    STAT_NOT_PRESENT = 3'd2,
    STAT_ALREADY     = 3'd3,
    STAT_POOL_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [FRAME_W-1:0] frame;
    logic               rel;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } dir_entry_t;

  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } pte_t;

endpackage

`default_nettype wire

// ===== src/two_level_page_map_top.sv =====
// top level of the two-level page map
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  tuser req_type; tdata va, frame, release
//   m_        out        m_tvalid/m_tready  tdata phys_addr, status, freed frame/valid
//   cfg_      in         cfg_we             cfg_index, cfg_data
//
// the back end handles each request as a directory read, a page read,
// then result and page write-back; the front and a 2-entry queue take new items meanwhile
// after reset a clearing pass writes every one of the 65536 page entries, with s_tready low
// a stalled result holds the back end in its last step until m_tready
`default_nettype none
`include "two_level_page_map_top_macros.svh"

module two_level_page_map_top import tlpm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // virt_addr[31:0], phys_frame[51:32], release_frame[52], zero[55:53]
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // phys_addr[31:0], status[34:32], freed_frame[54:35], freed_valid[55]
  output logic [TDATA_OUT_W-1:0]      m_tdata
);

  logic push;
  req_t push_data;
  logic q_full;
  logic q_valid;
  req_t q_head;
  logic pop;
  logic clearing;

  tlpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data)
  );

  tlpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tlpm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `TLPM_ASSERT_IMP(a_no_accept_clearing, clearing, !s_tready)
  `TLPM_ASSERT_NXT(a_clear_not_restarted, !clearing, !clearing)
  `TLPM_ASSERT_IMP(a_freed_only_ok, m_tvalid && m_tdata[OUT_FV_BIT], m_tdata[OUT_ST_LSB +: ST_W] == STAT_OK)
  `TLPM_ASSERT_IMP(a_fail_zero_addr, m_tvalid && (m_tdata[OUT_ST_LSB +: ST_W] != STAT_OK), m_tdata[OUT_PA_LSB +: ADDR_W] == '0)

endmodule

`default_nettype wire

// ===== src/tlpm_front.sv =====
// front end: config registers, input handshake and request classification
`default_nettype none

module tlpm_front import tlpm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [TDATA_IN_W-1:0] s_tdata,
  input  wire logic [1:0]            s_tuser,
  input  wire logic                  q_full,
  input  wire logic                  clearing,
  output logic                       push,
  output req_t                       push_data
);

  logic              paging_on;
  logic [ADDR_W-1:0] load_offset;
  logic [ADDR_W-1:0] va;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_on   <= 1'b0;
      load_offset <= RESET_LOAD_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGING_ON:   paging_on   <= cfg_data[0];
        CFG_LOAD_OFFSET: load_offset <= cfg_data[ADDR_W-1:0];
      endcase
    end
  end

  assign s_tready = !q_full && !clearing;
  assign push     = s_tvalid && s_tready;
  assign va       = s_tdata[IN_VA_LSB +: ADDR_W];

  always_comb begin
    push_data.addr  = va;
    push_data.frame = s_tdata[IN_FR_LSB +: FRAME_W];
    push_data.rel   = s_tdata[IN_REL_BIT];
    unique case (s_tuser)
      REQ_XLATE: begin
        push_data.op = paging_on ? OP_XLATE : OP_DIRECT;
        if (!paging_on) begin
          push_data.addr = va - load_offset;
        end
      end
      REQ_MAP:   push_data.op = OP_MAP;
      REQ_UNMAP: push_data.op = OP_UNMAP;
      default:   push_data.op = OP_NULL;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tlpm_queue.sv =====
// short request queue between front and back end
`default_nettype none

module tlpm_queue import tlpm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  req_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output req_t      head
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tlpm_back.sv =====
// back end: directory and page memories, table pool, walk sequencer, result register
`default_nettype none

module tlpm_back import tlpm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  req_t                        q_head,
  output logic                        pop,
  output logic                        clearing,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [TDATA_OUT_W-1:0]      m_tdata
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PAGE  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;

  dir_entry_t dir_mem [DIR_ENTRIES];
  pte_t       pg_mem  [PAGE_DEPTH];

  dir_entry_t dir_q;
  pte_t       pg_q;

  req_t                  cur;
  status_t               pre_st;
  logic [PG_AW-1:0]      pg_addr;
  logic [PG_AW-1:0]      clr_idx;
  logic [SLOT_CNT_W-1:0] slots_used;

  logic [DIR_AW-1:0] di;
  logic [TBL_AW-1:0] ti;
  logic              need_alloc;
  logic              pool_full;
  logic              alloc;
  logic [SLOT_W-1:0] slot_sel;
  status_t           page_st;
  logic              emit;

  logic              dir_we;
  logic [DIR_AW-1:0] dir_waddr;
  dir_entry_t        dir_wdata;
  logic              pg_we;
  logic [PG_AW-1:0]  pg_waddr;
  pte_t              pg_wdata;

  logic [ADDR_W-1:0]  r_pa;
  status_t            r_st;
  logic [FRAME_W-1:0] r_ff;
  logic               r_fv;
  logic               wb;
  pte_t               wb_data;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && q_valid;
  assign di       = cur.addr[ADDR_W-1 -: DIR_AW];
  assign ti       = cur.addr[PAGE_SHIFT +: TBL_AW];
  assign emit     = (state == S_EXEC) && (!m_tvalid || m_tready);

  // directory stage: pool allocation and early failures
  always_comb begin
    need_alloc = (cur.op == OP_MAP) && !dir_q.valid;
    pool_full  = (slots_used == SLOT_CNT_W'(TABLE_SLOTS));
    alloc      = (state == S_PAGE) && need_alloc && !pool_full;
    slot_sel   = need_alloc ? slots_used[SLOT_W-1:0] : dir_q.slot;
    page_st    = STAT_OK;
    if ((cur.op == OP_XLATE || cur.op == OP_UNMAP) && !dir_q.valid) begin
      page_st = STAT_NO_TABLE;
    end else if (need_alloc && pool_full) begin
      page_st = STAT_POOL_FULL;
    end
  end

  // page stage: result and write-back
  always_comb begin
    r_pa    = '0;
    r_st    = STAT_OK;
    r_ff    = '0;
    r_fv    = 1'b0;
    wb      = 1'b0;
    wb_data = '0;
    unique case (cur.op)
      OP_DIRECT: r_pa = cur.addr;
      OP_XLATE: begin
        if (pre_st != STAT_OK) begin
          r_st = pre_st;
        end else if (!pg_q.present) begin
          r_st = STAT_NOT_PRESENT;
        end else begin
          r_pa = {pg_q.frame, cur.addr[PAGE_SHIFT-1:0]};
        end
      end
      OP_MAP: begin
        if (pre_st != STAT_OK) begin
          r_st = pre_st;
        end else if (pg_q.present) begin
          r_st = STAT_ALREADY;
        end else begin
          wb      = 1'b1;
          wb_data = '{present: 1'b1, frame: cur.frame};
        end
      end
      OP_UNMAP: begin
        if (pre_st != STAT_OK) begin
          r_st = pre_st;
        end else if (!pg_q.present) begin
          r_st = STAT_NOT_PRESENT;
        end else begin
          r_ff = pg_q.frame;
          r_fv = cur.rel;
          wb   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    dir_we    = clearing || alloc;
    dir_waddr = clearing ? clr_idx[DIR_AW-1:0] : di;
    dir_wdata = clearing ? dir_entry_t'('0)
                         : dir_entry_t'{valid: 1'b1, slot: slots_used[SLOT_W-1:0]};
    pg_we     = clearing || (emit && wb);
    pg_waddr  = clearing ? clr_idx : pg_addr;
    pg_wdata  = clearing ? pte_t'('0) : wb_data;
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (pop) begin
      dir_q <= dir_mem[q_head.addr[ADDR_W-1 -: DIR_AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) begin
      pg_mem[pg_waddr] <= pg_wdata;
    end
    if (state == S_PAGE) begin
      pg_q <= pg_mem[{slot_sel, ti}];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == PG_AW'(PAGE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (q_valid) state_next = S_PAGE;
      S_PAGE:  state_next = S_EXEC;
      S_EXEC:  if (emit) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (state == S_PAGE) begin
      pre_st  <= page_st;
      pg_addr <= {slot_sel, ti};
    end
    if (emit) begin
      m_tdata <= {r_fv, r_ff, r_st, r_pa};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      slots_used <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (alloc) begin
        slots_used <= slots_used + 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
